### rtl/core/ddo_pkg.sv
package ddo_pkg;

   typedef struct packed {
      logic signed [31:0] count_a;
      logic signed [31:0] count_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic        [31:0] heading;
      logic signed [31:0] step_x;
      logic signed [31:0] step_y;
      logic signed [31:0] step_heading;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } rsp_type;

   typedef struct packed {
      logic        integration_mode;
      logic        swap_sides;
      logic        invert_wheel_a;
      logic        invert_wheel_b;
      logic [31:0] meters_per_step;
      logic [31:0] angle_per_step_diff;
   } cfg_type;

   localparam logic [1:0] MUL_TRAVEL = 2'd0;
   localparam logic [1:0] MUL_HEAD   = 2'd1;
   localparam logic [1:0] MUL_X      = 2'd2;
   localparam logic [1:0] MUL_Y      = 2'd3;

   localparam logic CORDIC_MOTION = 1'b0;
   localparam logic CORDIC_QUAT   = 1'b1;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_SWAP   = 3'd1;
   localparam logic [2:0] REG_INV_A  = 3'd2;
   localparam logic [2:0] REG_INV_B  = 3'd3;
   localparam logic [2:0] REG_MPS    = 3'd4;
   localparam logic [2:0] REG_APS    = 3'd5;

   localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

   typedef struct packed {
      logic       load_in;
      logic [1:0] mul_sel;
      logic       travel_ld;
      logic       dh_ld;
      logic       cordic_init;
      logic       cordic_sel;
      logic       cordic_step;
      logic [4:0] cordic_idx;
      logic       sx_ld;
      logic       sy_ld;
      logic       acc_ld;
      logic       out_ld;
   } cmd_type;

   function automatic logic [31:0] atan_turns(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/ddo_csr.sv
module ddo_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output ddo_pkg::cfg_type   cfg
);
   import ddo_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_MODE:  cfg_in.integration_mode    = pwdata[0];
            REG_SWAP:  cfg_in.swap_sides          = pwdata[0];
            REG_INV_A: cfg_in.invert_wheel_a      = pwdata[0];
            REG_INV_B: cfg_in.invert_wheel_b      = pwdata[0];
            REG_MPS:   cfg_in.meters_per_step     = pwdata;
            REG_APS:   cfg_in.angle_per_step_diff = pwdata;
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_MODE:  prdata = {31'd0, cfg_ff.integration_mode};
         REG_SWAP:  prdata = {31'd0, cfg_ff.swap_sides};
         REG_INV_A: prdata = {31'd0, cfg_ff.invert_wheel_a};
         REG_INV_B: prdata = {31'd0, cfg_ff.invert_wheel_b};
         REG_MPS:   prdata = cfg_ff.meters_per_step;
         REG_APS:   prdata = cfg_ff.angle_per_step_diff;
         default:   prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.integration_mode    <= 1'b0;
         cfg_ff.swap_sides          <= 1'b1;
         cfg_ff.invert_wheel_a      <= 1'b0;
         cfg_ff.invert_wheel_b      <= 1'b0;
         cfg_ff.meters_per_step     <= 32'd4294967;
         cfg_ff.angle_per_step_diff <= 32'd349985280;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/ddo_ctrl.sv
module ddo_ctrl #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ddo_pkg::cmd_type cmd
);
   import ddo_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MT   = 4'd1;
   localparam logic [3:0] S_MH   = 4'd2;
   localparam logic [3:0] S_HD   = 4'd3;
   localparam logic [3:0] S_CI1  = 4'd4;
   localparam logic [3:0] S_CR1  = 4'd5;
   localparam logic [3:0] S_MX   = 4'd6;
   localparam logic [3:0] S_MY   = 4'd7;
   localparam logic [3:0] S_SY   = 4'd8;
   localparam logic [3:0] S_ACC  = 4'd9;
   localparam logic [3:0] S_CI2  = 4'd10;
   localparam logic [3:0] S_CR2  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   localparam logic [4:0] LAST = 5'(CORDIC_STAGES - 1);

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_sel    = MUL_TRAVEL;
      cmd.cordic_idx = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MT;
            end
         end
         S_MT: begin
            cmd.mul_sel = MUL_TRAVEL;
            state_in    = S_MH;
         end
         S_MH: begin
            cmd.mul_sel   = MUL_HEAD;
            cmd.travel_ld = 1'b1;
            state_in      = S_HD;
         end
         S_HD: begin
            cmd.dh_ld = 1'b1;
            state_in  = S_CI1;
         end
         S_CI1: begin
            cmd.cordic_init = 1'b1;
            cmd.cordic_sel  = CORDIC_MOTION;
            cnt_in          = 5'd0;
            state_in        = S_CR1;
         end
         S_CR1: begin
            cmd.cordic_step = 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_MX;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_MX: begin
            cmd.mul_sel = MUL_X;
            state_in    = S_MY;
         end
         S_MY: begin
            cmd.mul_sel = MUL_Y;
            cmd.sx_ld   = 1'b1;
            state_in    = S_SY;
         end
         S_SY: begin
            cmd.sy_ld = 1'b1;
            state_in  = S_ACC;
         end
         S_ACC: begin
            cmd.acc_ld = 1'b1;
            state_in   = S_CI2;
         end
         S_CI2: begin
            cmd.cordic_init = 1'b1;
            cmd.cordic_sel  = CORDIC_QUAT;
            cnt_in          = 5'd0;
            state_in        = S_CR2;
         end
         S_CR2: begin
            cmd.cordic_step = 1'b1;
            if (cnt_ff == LAST) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_ld) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_MT))
      else $error("accepted item did not start processing");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST)
      else $error("cordic iteration count out of range");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!valid_ff || rsp_ready))
      else $error("result register overwritten while pending");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |=> valid_ff)
      else $error("loaded result not presented");
`endif

endmodule

### rtl/core/ddo_dp.sv
module ddo_dp (
   input  logic             clock,
   input  logic             reset,
   input  ddo_pkg::req_type req_data,
   input  ddo_pkg::cfg_type cfg,
   input  ddo_pkg::cmd_type cmd,
   output ddo_pkg::rsp_type rsp_data
);
   import ddo_pkg::*;

   logic [31:0]        prev_a_ff, prev_b_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff;
   logic [31:0]        acc_h_ff;
   logic signed [31:0] d1_ff, d2_ff;
   logic signed [67:0] mul_ff;
   logic signed [31:0] travel_ff, travel_in;
   logic [31:0]        dh_ff, dh_in;
   logic signed [32:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic signed [31:0] sx_ff, sy_ff;
   rsp_type            out_ff;

   logic [31:0]        da, db, ea, eb;
   logic signed [32:0] sum, mag, diff;
   logic [46:0]        prod;
   logic [63:0]        hlo;
   logic signed [33:0] mul_a, mul_b;
   logic [31:0]        ang, ang_r, half;
   logic               flip_in;
   logic signed [32:0] cos_v, sin_v, sx_sh, sy_sh;
   logic signed [32:0] nx, ny, nz, atn;
   logic signed [37:0] step_sh;
   logic signed [31:0] step_sat;
   logic signed [32:0] pxs, pys;
   logic signed [31:0] pxn, pyn;
   logic signed [33:0] qcr, qsr;
   logic signed [18:0] qcs, qss;
   logic signed [15:0] qz, qw;

   always_comb begin
      da = req_data.count_a - prev_a_ff;
      db = req_data.count_b - prev_b_ff;
      if (cfg.invert_wheel_a) da = 32'd0 - da;
      if (cfg.invert_wheel_b) db = 32'd0 - db;
      ea = cfg.swap_sides ? db : da;
      eb = cfg.swap_sides ? da : db;
   end

   assign sum  = 33'(d1_ff) + 33'(d2_ff);
   assign mag  = sum[32] ? -sum : sum;
   assign diff = 33'(d2_ff) - 33'(d1_ff);

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_TRAVEL: begin
            mul_a = {2'b00, mag[31:0]};
            mul_b = {2'b00, cfg.meters_per_step};
         end
         MUL_HEAD: begin
            mul_a = {2'b00, diff[31:0]};
            mul_b = {2'b00, cfg.angle_per_step_diff};
         end
         MUL_X: begin
            mul_a = 34'(travel_ff);
            mul_b = 34'(cos_v);
         end
         default: begin
            mul_a = 34'(travel_ff);
            mul_b = 34'(sin_v);
         end
      endcase
   end

   always_comb begin
      prod = mag[32] ? {cfg.meters_per_step, 15'd0} : mul_ff[63:17];
      if (sum[32]) begin
         travel_in = (prod > 47'h80000000) ? 32'sh80000000 : -$signed(prod[31:0]);
      end else begin
         travel_in = (prod > 47'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(prod[31:0]);
      end
      hlo   = mul_ff[63:0] - (diff[32] ? {cfg.angle_per_step_diff, 32'd0} : 64'd0);
      dh_in = hlo[39:8];
   end

   always_comb begin
      half = {dh_ff[31], dh_ff[31:1]};
      if (cmd.cordic_sel == CORDIC_QUAT) begin
         ang = {1'b0, acc_h_ff[31:1]};
      end else if (cfg.integration_mode) begin
         ang = acc_h_ff + half;
      end else begin
         ang = acc_h_ff;
      end
      flip_in = ang[31] ^ ang[30];
      ang_r   = flip_in ? ang + 32'h80000000 : ang;
   end

   always_comb begin
      sx_sh = cx_ff >>> cmd.cordic_idx;
      sy_sh = cy_ff >>> cmd.cordic_idx;
      atn   = 33'(atan_turns(cmd.cordic_idx));
      if (!cz_ff[32]) begin
         nx = cx_ff - sy_sh;
         ny = cy_ff + sx_sh;
         nz = cz_ff - atn;
      end else begin
         nx = cx_ff + sy_sh;
         ny = cy_ff - sx_sh;
         nz = cz_ff + atn;
      end
      cos_v = flip_ff ? -cx_ff : cx_ff;
      sin_v = flip_ff ? -cy_ff : cy_ff;
   end

   always_comb begin
      step_sh = 38'(mul_ff >>> 30);
      if (step_sh > 38'sh007FFFFFFF) begin
         step_sat = 32'sh7FFFFFFF;
      end else if (step_sh < -38'sh0080000000) begin
         step_sat = 32'sh80000000;
      end else begin
         step_sat = step_sh[31:0];
      end
      pxs = 33'(acc_x_ff) + 33'(sx_ff);
      pys = 33'(acc_y_ff) + 33'(sy_ff);
      pxn = (pxs[32] != pxs[31]) ? (pxs[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : pxs[31:0];
      pyn = (pys[32] != pys[31]) ? (pys[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : pys[31:0];
   end

   always_comb begin
      qcr = 34'(cos_v) + 34'sd16384;
      qsr = 34'(sin_v) + 34'sd16384;
      qcs = qcr[33:15];
      qss = qsr[33:15];
      if (qcs > 19'sd32767) qw = 16'sh7FFF;
      else if (qcs < -19'sd32768) qw = 16'sh8000;
      else qw = qcs[15:0];
      if (qss > 19'sd32767) qz = 16'sh7FFF;
      else if (qss < -19'sd32768) qz = 16'sh8000;
      else qz = qss[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 32'd0;
         prev_b_ff <= 32'd0;
         acc_x_ff  <= 32'sd0;
         acc_y_ff  <= 32'sd0;
         acc_h_ff  <= 32'd0;
      end else begin
         if (cmd.load_in) begin
            prev_a_ff <= req_data.count_a;
            prev_b_ff <= req_data.count_b;
         end
         if (cmd.acc_ld) begin
            acc_x_ff <= pxn;
            acc_y_ff <= pyn;
            acc_h_ff <= acc_h_ff + dh_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (cmd.load_in) begin
         d1_ff <= ea;
         d2_ff <= eb;
      end
      if (cmd.travel_ld) travel_ff <= travel_in;
      if (cmd.dh_ld)     dh_ff     <= dh_in;
      if (cmd.sx_ld)     sx_ff     <= step_sat;
      if (cmd.sy_ld)     sy_ff     <= step_sat;
      if (cmd.cordic_init) begin
         cx_ff   <= CORDIC_K;
         cy_ff   <= 33'sd0;
         cz_ff   <= 33'($signed(ang_r));
         flip_ff <= flip_in;
      end else if (cmd.cordic_step) begin
         cx_ff <= nx;
         cy_ff <= ny;
         cz_ff <= nz;
      end
      if (cmd.out_ld) begin
         out_ff.pos_x        <= acc_x_ff;
         out_ff.pos_y        <= acc_y_ff;
         out_ff.heading      <= acc_h_ff;
         out_ff.step_x       <= sx_ff;
         out_ff.step_y       <= sy_ff;
         out_ff.step_heading <= dh_ff;
         out_ff.quat_z       <= qz;
         out_ff.quat_w       <= qw;
      end
   end

   assign rsp_data = out_ff;

endmodule

### rtl/core/diff_drive_odometry.sv
// Differential-drive odometry: each item carries two absolute wheel counts and yields one
// pose result. Each item makes two passes through the single iterative CORDIC unit and
// uses the shared 34x34 signed multiplier. The next item can be taken the cycle after the
// result is loaded; the load waits while an earlier result is still pending. A new item is
// taken once the previous one has left the datapath, even while its result still waits in
// the output register. Configuration sits on an APB port at byte offsets 0,4,..,20; the user
// must write it only while the block is idle, which the block itself does not enforce.
module diff_drive_odometry #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ddo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ddo_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ddo_pkg::*;

   cfg_type cfg;
   cmd_type cmd;

   ddo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ddo_ctrl #(
      .CORDIC_STAGES (CORDIC_STAGES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ddo_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .rsp_data (rsp_data)
   );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ddo_pkg::*;

   localparam int STAGES = 16;
   localparam longint TWO31 = 64'sd2147483648;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   int error_count = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;

   always #5 clock = ~clock;

   diff_drive_odometry #(.CORDIC_STAGES(STAGES)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic longint sat32(input longint v);
      if (v > TWO31 - 1) return TWO31 - 1;
      if (v < -TWO31) return -TWO31;
      return v;
   endfunction

   function automatic longint floor_shr(input longint v, input int s);
      return v >>> s;
   endfunction

   task automatic rotate(input logic [31:0] angle, output longint c, output longint s);
      logic [31:0] a;
      logic [31:0] t;
      bit flip;
      longint x, y, z, nx;
      int n;
      a = angle;
      flip = 1'b0;
      t = a + 32'h40000000;
      if (t[31]) begin
         a = a + 32'h80000000;
         flip = 1'b1;
      end
      x = 652032874;
      y = 0;
      z = longint'(signed'(a));
      n = (STAGES > 32) ? 32 : STAGES;
      for (int i = 0; i < n; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= longint'(atan_turns(i[4:0]));
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += longint'(atan_turns(i[4:0]));
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic logic [15:0] to_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   class odometry_scoreboard;
      cfg_type cfg;
      logic [31:0] last_a, last_b, pos_x, pos_y, heading;
      rsp_type pending[$];

      function void clear();
         cfg.integration_mode = 1'b0;
         cfg.swap_sides = 1'b1;
         cfg.invert_wheel_a = 1'b0;
         cfg.invert_wheel_b = 1'b0;
         cfg.meters_per_step = 32'd4294967;
         cfg.angle_per_step_diff = 32'd349985280;
         last_a = '0; last_b = '0; pos_x = '0; pos_y = '0; heading = '0;
      endfunction

      task note_counts(input req_type r);
         logic [31:0] da, db, t, dh, ang;
         longint d1, d2, sum, travel, c, s, sx, sy, qc, qs;
         logic [63:0] mag, prod, hprod;
         rsp_type e;
         da = r.count_a - last_a;
         db = r.count_b - last_b;
         last_a = r.count_a;
         last_b = r.count_b;
         if (cfg.invert_wheel_a) da = -da;
         if (cfg.invert_wheel_b) db = -db;
         if (cfg.swap_sides) begin
            t = da; da = db; db = t;
         end
         d1 = longint'(signed'(da));
         d2 = longint'(signed'(db));
         sum = d1 + d2;
         mag = (sum < 0) ? -sum : sum;
         prod = (mag * {32'd0, cfg.meters_per_step}) >> 17;
         travel = sat32(sum < 0 ? -longint'(prod) : longint'(prod));
         hprod = 64'(d2 - d1) * {32'd0, cfg.angle_per_step_diff};
         dh = hprod[39:8];
         ang = cfg.integration_mode ? heading + {dh[31], dh[31:1]} : heading;
         rotate(ang, c, s);
         sx = sat32(floor_shr(travel * c, 30));
         sy = sat32(floor_shr(travel * s, 30));
         pos_x = 32'(sat32(longint'(signed'(pos_x)) + sx));
         pos_y = 32'(sat32(longint'(signed'(pos_y)) + sy));
         heading += dh;
         rotate({1'b0, heading[31:1]}, qc, qs);
         e.pos_x = pos_x;
         e.pos_y = pos_y;
         e.heading = heading;
         e.step_x = 32'(sx);
         e.step_y = 32'(sy);
         e.step_heading = dh;
         e.quat_z = to_q15(qs);
         e.quat_w = to_q15(qc);
         pending.push_back(e);
      endtask

      task check_pose(input rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected item", g.pos_x, 0);
            return;
         end
         e = pending.pop_front();
         if (g.pos_x !== e.pos_x) report("pos_x", g.pos_x, e.pos_x);
         if (g.pos_y !== e.pos_y) report("pos_y", g.pos_y, e.pos_y);
         if (g.heading !== e.heading) report("heading", g.heading, e.heading);
         if (g.step_x !== e.step_x) report("step_x", g.step_x, e.step_x);
         if (g.step_y !== e.step_y) report("step_y", g.step_y, e.step_y);
         if (g.step_heading !== e.step_heading)
            report("step_heading", g.step_heading, e.step_heading);
         if (g.quat_z !== e.quat_z) report("quat_z", g.quat_z, e.quat_z);
         if (g.quat_w !== e.quat_w) report("quat_w", g.quat_w, e.quat_w);
      endtask
   endclass

   odometry_scoreboard pose_board = new();

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) pose_board.note_counts(req_data);
      if (!reset && rsp_valid && rsp_ready) pose_board.check_pose(rsp_data);
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            hold_cycles++;
         end else begin
            g = gap_length();
            rsp_ready <= (g == 0) || ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_MODE:  pose_board.cfg.integration_mode = value[0];
         REG_SWAP:  pose_board.cfg.swap_sides = value[0];
         REG_INV_A: pose_board.cfg.invert_wheel_a = value[0];
         REG_INV_B: pose_board.cfg.invert_wheel_b = value[0];
         REG_MPS:   pose_board.cfg.meters_per_step = value;
         REG_APS:   pose_board.cfg.angle_per_step_diff = value;
         default: ;
      endcase
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_counts(input logic [31:0] a, input logic [31:0] b, input bit gaps);
      int g;
      req_data <= {a, b};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pose_board.pending.size() != 0) @(posedge clock);
      repeat (2 * STAGES + 20) @(posedge clock);
   endtask

   task automatic set_all(input bit m, input bit s, input bit ia, input bit ib,
                          input logic [31:0] mps, input logic [31:0] aps);
      csr_write(REG_MODE, 32'(m));
      csr_write(REG_SWAP, 32'(s));
      csr_write(REG_INV_A, 32'(ia));
      csr_write(REG_INV_B, 32'(ib));
      csr_write(REG_MPS, mps);
      csr_write(REG_APS, aps);
   endtask

   // wheels driven by a random walk so most samples are plausible motion
   task automatic random_run(input int n);
      logic [31:0] a, b;
      int k;
      a = pose_board.last_a;
      b = pose_board.last_b;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 9);
         if (k < 7) begin
            a += 32'($signed($urandom_range(0, 400)) - 200);
            b += 32'($signed($urandom_range(0, 400)) - 200);
         end else if (k < 9) begin
            a += 32'($signed($urandom_range(0, 200000)) - 100000);
            b += 32'($signed($urandom_range(0, 200000)) - 100000);
         end else begin
            a = $urandom();
            b = $urandom();
         end
         send_counts(a, b, 1'b1);
      end
   endtask

   initial begin
      pose_board.clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset config, extremes of counts and wrap of deltas
      send_counts(32'd0, 32'd0, 1'b0);
      send_counts(32'd100, 32'd100, 1'b0);
      send_counts(32'd100, 32'd300, 1'b0);
      send_counts(32'h7FFFFFFF, 32'h80000000, 1'b0);
      send_counts(32'h80000000, 32'h7FFFFFFF, 1'b0);
      send_counts(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
      send_counts(32'h00000000, 32'h80000000, 1'b0);
      drain();
      set_all(1'b1, 1'b0, 1'b1, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_counts(32'h80000000, 32'h00000000, 1'b0);
      send_counts(32'h00000000, 32'h00000000, 1'b0);
      send_counts(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      send_counts(32'h80000000, 32'h80000000, 1'b0);
      send_counts(32'h00001000, 32'hFFFFF000, 1'b0);
      drain();
      set_all(1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0);
      send_counts(32'd5000, -32'sd5000, 1'b0);
      send_counts(32'h55555555, 32'hAAAAAAAA, 1'b0);
      drain();
      set_all(1'b1, 1'b0, 1'b0, 1'b1, 32'd1, 32'h40000000);
      send_counts(32'd1, 32'd2, 1'b0);
      send_counts(32'd3, 32'd7, 1'b0);
      send_counts(32'd100, 32'd80, 1'b0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         set_all(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 (phase == 0) ? 32'hFFFFFFFF : (phase == 1) ? 32'd1 :
                    $urandom_range(1000, 40000000),
                 (phase == 2) ? 32'hFFFFFFFF : (phase == 3) ? 32'd0 : $urandom());
         if (phase == 2) begin
            hold_rsp = 1'b1;
            fork
               begin
                  hold_cycles = 0;
                  while (hold_cycles < 400) @(posedge clock);
                  hold_rsp = 1'b0;
               end
               random_run(10);
            join
         end
         random_run(140);
         if (phase == 4) begin
            req_valid <= 1'b0;
            while (pose_board.pending.size() != 0) @(posedge clock);
         end
         random_run(5);
         drain();
      end

      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

### sim.f
rtl/core/ddo_pkg.sv
rtl/core/ddo_csr.sv
rtl/core/ddo_ctrl.sv
rtl/core/ddo_dp.sv
rtl/core/diff_drive_odometry.sv
tb/sv/testbench.sv
